FILE: rtl/fbb_pkg.sv
`default_nettype none
package fbb_pkg;
	localparam int unsigned LossDepthDef = 256;
	localparam int unsigned RegW = 32;
	localparam int unsigned NumRegs = 5;

	typedef enum logic [2:0] {
		REG_MIN_RATE   = 3'd0,
		REG_START_RATE = 3'd1,
		REG_MAX_RATE   = 3'd2,
		REG_PRESS_LVL  = 3'd3,
		REG_RECOV_LVL  = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		EV_NONE     = 4'd0,
		EV_ACK      = 4'd1,
		EV_LOST     = 4'd2,
		EV_CANCELED = 4'd3,
		EV_QUEUE    = 4'd4,
		EV_CLOSS    = 4'd5,
		EV_RENDERED = 4'd6,
		EV_AWAIT    = 4'd7,
		EV_KEYREQ   = 4'd8
	} ev_kind_t;

	typedef enum logic [3:0] {
		WHY_BAD_PLAN  = 4'd0,
		WHY_BAD_EVENT = 4'd1,
		WHY_STALE     = 4'd2,
		WHY_ACK       = 4'd3,
		WHY_LOSS      = 4'd4,
		WHY_CANCELED  = 4'd5,
		WHY_DUP       = 4'd6,
		WHY_MIN_HELD  = 4'd7,
		WHY_DROP      = 4'd8,
		WHY_PRESSURE  = 4'd9,
		WHY_RECOVERED = 4'd10,
		WHY_STABLE    = 4'd11,
		WHY_CLOSS     = 4'd12,
		WHY_RENDERED  = 4'd13,
		WHY_AWAIT     = 4'd14,
		WHY_REQUEST   = 4'd15
	} why_t;

	typedef struct packed {
		logic        op;
		logic [63:0] session_tag;
		logic [3:0]  event_kind;
		logic [31:0] event_seq;
		logic [63:0] frame_id;
		logic [31:0] drop_count;
		logic [31:0] queue_depth;
		logic [31:0] chunk_misses;
	} fbb_in_t;

	typedef struct packed {
		logic        accepted;
		logic [31:0] decision_num;
		logic [3:0]  why;
		logic [31:0] rate_before;
		logic [31:0] rate_after;
		logic        rate_changed;
		logic        want_keyframe;
	} fbb_out_t;
endpackage
`default_nettype wire

FILE: rtl/fbb_stream_if.sv
`default_nettype none
interface fbb_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/feedback_bitrate_backoff_top.sv
// A start or an event that keeps the rate passes ST_EVAL and ST_OUT; a queue event that
// cuts it passes ST_EVAL, ST_CUT and ST_OUT. A loss event walks the frame-id ring one
// entry a cycle through ST_READ and ST_CMP: a duplicate goes from ST_CMP to ST_OUT, a new
// id is stored and goes on through ST_CUT. Throughput: one item at a time; the next item is
// taken the cycle after the result is taken. Reset (arst_n low) clears all control state;
// registers take their reset values and the ring is empty, so it needs no clearing pass.
`default_nettype none
module feedback_bitrate_backoff_top
	import fbb_pkg::*;
#(
	parameter int unsigned LOSS_DEPTH = LossDepthDef
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	fbb_stream_if.sink             in_ch,
	fbb_stream_if.source           out_ch,
	input  wire logic              cfg_we,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [RegW-1:0]   cfg_data
);
	localparam int unsigned AW = (LOSS_DEPTH > 1) ? $clog2(LOSS_DEPTH) : 1;
	localparam int unsigned CW = $clog2(LOSS_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_EVAL, ST_READ, ST_CMP, ST_CUT, ST_OUT
	} state_t;

	state_t      state_q;
	fbb_in_t     item_q;
	fbb_out_t    res_q;
	logic        out_valid_q;
	logic [31:0] min_q, start_q, max_q, press_q, recov_q;
	logic [31:0] rate_q, drop_tot_q, seq_q;
	logic [63:0] sess_q;
	logic        press_on_q;
	logic [CW-1:0] count_q, idx_q;
	logic [AW-1:0] head_q;
	logic [63:0] loss_mem [LOSS_DEPTH];
	logic [63:0] rd_data_q;
	logic        mem_we;
	logic [AW-1:0] mem_waddr, rd_addr;
	logic [CW-1:0] rd_idx;
	logic        plan_ok;
	logic [31:0] red, cand;

	assign plan_ok = (min_q != '0) && (min_q <= start_q) && (start_q <= max_q);
	assign in_ch.ready = (state_q == ST_IDLE) && !out_valid_q;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = res_q;

	// Ring address of the idx-th oldest entry, wrapped
	function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base,
		input logic [CW-1:0] off);
		logic [AW+CW:0] s;
		logic [AW+CW:0] d;
		s = {{(CW+1){1'b0}}, base} + {{(AW+1){1'b0}}, off};
		d = (AW+CW+1)'(LOSS_DEPTH);
		if (s >= d) s = s - d;
		return s[AW-1:0];
	endfunction

	// Read ahead while comparing, so the walk takes one entry a cycle
	assign rd_idx = (state_q == ST_CMP) ? idx_q + CW'(1) : idx_q;
	assign rd_addr = wrap(head_q, rd_idx);

	// Cut candidate: rate - max(1, rate/8), floored at min
	always_comb begin
		red = rate_q >> 3;
		if (red == '0) red = 32'd1;
		cand = (rate_q > red) ? rate_q - red : min_q;
		if (cand < min_q) cand = min_q;
	end

	// Ring memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (mem_we) loss_mem[mem_waddr] <= item_q.frame_id;
		rd_data_q <= loss_mem[rd_addr];
	end

	always_comb begin
		mem_we = (state_q == ST_CMP) && (idx_q == count_q);
		mem_waddr = (count_q == CW'(LOSS_DEPTH)) ? head_q : wrap(head_q, count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			min_q <= '0; start_q <= '0; max_q <= '0;
			press_q <= 32'd3; recov_q <= 32'd1;
			rate_q <= '0; drop_tot_q <= '0; seq_q <= '0; sess_q <= '0;
			press_on_q <= 1'b0; count_q <= '0; head_q <= '0; idx_q <= '0;
		end else begin
			if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
			// Configuration: write register, reload rate
			if (cfg_we && cfg_index <= REG_RECOV_LVL) begin
				logic [31:0] mn, st, mx;
				mn = (cfg_index == REG_MIN_RATE) ? cfg_data : min_q;
				st = (cfg_index == REG_START_RATE) ? cfg_data : start_q;
				mx = (cfg_index == REG_MAX_RATE) ? cfg_data : max_q;
				min_q <= mn; start_q <= st; max_q <= mx;
				if (cfg_index == REG_PRESS_LVL) press_q <= cfg_data;
				if (cfg_index == REG_RECOV_LVL) recov_q <= cfg_data;
				rate_q <= (mn != '0 && mn <= st && st <= mx) ? st : '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						item_q <= in_ch.data;
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					fbb_out_t r;
					state_t nxt;
					r = '0;
					r.rate_before = rate_q;
					r.rate_after = rate_q;
					nxt = ST_OUT;
					idx_q <= '0;
					if (!item_q.op) begin
						// Session start
						if (plan_ok && item_q.session_tag != '0) begin
							r.accepted = 1'b1;
							sess_q <= item_q.session_tag;
							drop_tot_q <= '0; press_on_q <= 1'b0;
							count_q <= '0; head_q <= '0;
						end
					end else begin
						r.accepted = 1'b1;
						r.decision_num = seq_q;
						seq_q <= seq_q + 32'd1;
						if (!plan_ok) begin
							r.why = WHY_BAD_PLAN;
						end else if (item_q.event_kind == EV_NONE ||
							item_q.event_kind > EV_KEYREQ || item_q.event_seq == '0) begin
							r.why = WHY_BAD_EVENT;
						end else if (sess_q == '0 || item_q.session_tag != sess_q) begin
							r.why = WHY_STALE;
						end else begin
							unique case (ev_kind_t'(item_q.event_kind))
								EV_ACK: r.why = WHY_ACK;
								EV_CANCELED: r.why = WHY_CANCELED;
								EV_RENDERED: r.why = WHY_RENDERED;
								EV_AWAIT: begin
									r.why = WHY_AWAIT; r.want_keyframe = 1'b1;
								end
								EV_LOST, EV_CLOSS: begin
									r.want_keyframe = 1'b1;
									if (item_q.frame_id == '0 || (item_q.event_kind == EV_CLOSS
										&& item_q.chunk_misses == '0)) begin
										r.why = WHY_BAD_EVENT;
									end else begin
										r.why = (item_q.event_kind == EV_LOST) ?
											WHY_LOSS : WHY_CLOSS;
										nxt = ST_READ;
									end
								end
								EV_QUEUE: begin
									logic nd, pr, rc, pon;
									if (item_q.drop_count < drop_tot_q) begin
										r.why = WHY_BAD_EVENT;
									end else begin
										nd = item_q.drop_count > drop_tot_q;
										drop_tot_q <= item_q.drop_count;
										pr = item_q.queue_depth >= press_q;
										rc = press_on_q && item_q.queue_depth <= recov_q;
										pon = press_on_q && !rc;
										if (nd) begin
											press_on_q <= pon || pr;
											r.why = WHY_DROP;
											r.want_keyframe = 1'b1;
											nxt = ST_CUT;
										end else if (pr && !pon) begin
											press_on_q <= 1'b1;
											r.why = WHY_PRESSURE;
											nxt = ST_CUT;
										end else begin
											press_on_q <= pon;
											r.why = rc ? WHY_RECOVERED : WHY_STABLE;
										end
									end
								end
								default: begin
									r.why = WHY_REQUEST; r.want_keyframe = 1'b1;
								end
							endcase
						end
					end
					res_q <= r;
					state_q <= nxt;
				end
				// Issue read of the oldest entry
				ST_READ: begin
					state_q <= ST_CMP;
				end
				// Compare, advance, or store at the end of the walk
				ST_CMP: begin
					if (idx_q == count_q) begin
						if (count_q == CW'(LOSS_DEPTH))
							head_q <= wrap(head_q, CW'(1));
						else
							count_q <= count_q + CW'(1);
						state_q <= ST_CUT;
					end else if (rd_data_q == item_q.frame_id) begin
						res_q.why <= WHY_DUP;
						state_q <= ST_OUT;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				ST_CUT: begin
					fbb_out_t r;
					r = res_q;
					if (rate_q <= min_q) begin
						r.why = WHY_MIN_HELD;
					end else begin
						r.rate_changed = cand != rate_q;
						r.rate_after = cand;
						rate_q <= cand;
					end
					res_q <= r;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: rtl/fbb_checker.sv
`default_nettype none
module fbb_checker
	import fbb_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     in_valid,
	input wire logic     in_ready,
	input wire logic     out_valid,
	input wire logic     out_ready,
	input wire fbb_out_t out_data
);
	// Output holds while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	// No new item while a result waits
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("ready with pending result");
	// Rate never rises on an event
	a_rate: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.rate_after <= out_data.rate_before)
		else $error("rate rose");
	// Changed flag matches rates
	a_chg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.rate_changed == (out_data.rate_after != out_data.rate_before))
		else $error("bad change flag");
endmodule

bind feedback_bitrate_backoff_top fbb_checker u_fbb_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
`default_nettype wire

FILE: sim/tb_feedback_bitrate_backoff_top.sv
module tb_feedback_bitrate_backoff_top;
	import fbb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RING = LossDepthDef;
	localparam int unsigned CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [RegW-1:0] cfg_data = '0;

	fbb_stream_if #(.payload_t(fbb_in_t)) in_ch ();
	fbb_stream_if #(.payload_t(fbb_out_t)) out_ch ();

	feedback_bitrate_backoff_top u_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// predictor state
	logic [31:0] p_min, p_start, p_max, p_press_lvl, p_recov_lvl;
	logic [31:0] p_rate, p_drops, p_num;
	logic [63:0] p_session;
	logic        p_pressure;
	logic [63:0] p_ring [RING];
	int unsigned p_ring_cnt, p_ring_head;

	fbb_out_t decisions_due [$];
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	bit sink_hold = 1'b0;
	bit no_idle = 1'b0;

	// recently used frame ids, reused to provoke duplicates
	logic [63:0] recent_frames [$];

	function automatic bit plan_valid();
		return p_min != 0 && p_min <= p_start && p_start <= p_max;
	endfunction

	function automatic void predict_reset();
		p_min = 0; p_start = 0; p_max = 0; p_press_lvl = 3; p_recov_lvl = 1;
		p_rate = 0; p_session = 0; p_drops = 0; p_pressure = 0;
		p_ring_cnt = 0; p_ring_head = 0; p_num = 0;
	endfunction

	function automatic void predict_config(reg_idx_t idx, logic [31:0] v);
		case (idx)
			REG_MIN_RATE:   p_min = v;
			REG_START_RATE: p_start = v;
			REG_MAX_RATE:   p_max = v;
			REG_PRESS_LVL:  p_press_lvl = v;
			REG_RECOV_LVL:  p_recov_lvl = v;
			default: ;
		endcase
		p_rate = plan_valid() ? p_start : 32'd0;
	endfunction

	// remember a lost frame; 0 when it is already known
	function automatic bit remember_loss(logic [63:0] id);
		for (int unsigned i = 0; i < p_ring_cnt; i++)
			if (p_ring[(p_ring_head + i) % RING] == id)
				return 1'b0;
		if (p_ring_cnt >= RING) begin
			p_ring[p_ring_head] = id;
			p_ring_head = (p_ring_head + 1) % RING;
		end else begin
			p_ring[(p_ring_head + p_ring_cnt) % RING] = id;
			p_ring_cnt++;
		end
		return 1'b1;
	endfunction

	function automatic void back_off(ref why_t why, ref logic chg);
		logic [31:0] cut, cand;
		if (p_rate <= p_min) begin
			why = WHY_MIN_HELD;
			return;
		end
		cut = p_rate / 8;
		if (cut < 1) cut = 1;
		cand = (p_rate > cut) ? p_rate - cut : p_min;
		if (cand < p_min) cand = p_min;
		chg = (cand != p_rate);
		p_rate = cand;
	endfunction

	function automatic fbb_out_t predict_decision(fbb_in_t it);
		fbb_out_t r;
		why_t why;
		logic chg, key, more_drops, press, recov;
		r = '0;
		why = WHY_BAD_PLAN; chg = 0; key = 0;
		if (it.op == 1'b0) begin
			r.accepted = plan_valid() && it.session_tag != 0;
			if (r.accepted) begin
				p_session = it.session_tag; p_drops = 0; p_pressure = 0;
				p_ring_cnt = 0; p_ring_head = 0;
			end
			r.rate_before = p_rate; r.rate_after = p_rate;
			return r;
		end
		r.accepted = 1'b1;
		r.decision_num = p_num;
		r.rate_before = p_rate;
		p_num++;
		if (!plan_valid())
			why = WHY_BAD_PLAN;
		else if (it.event_kind == EV_NONE || it.event_kind > EV_KEYREQ || it.event_seq == 0)
			why = WHY_BAD_EVENT;
		else if (p_session == 0 || it.session_tag != p_session)
			why = WHY_STALE;
		else begin
			case (ev_kind_t'(it.event_kind))
				EV_ACK: why = WHY_ACK;
				EV_LOST, EV_CLOSS: begin
					why = (it.event_kind == EV_LOST) ? WHY_LOSS : WHY_CLOSS;
					key = 1;
					if (it.frame_id == 0 || (it.event_kind == EV_CLOSS && it.chunk_misses == 0))
						why = WHY_BAD_EVENT;
					else if (!remember_loss(it.frame_id))
						why = WHY_DUP;
					else
						back_off(why, chg);
				end
				EV_CANCELED: why = WHY_CANCELED;
				EV_QUEUE: begin
					if (it.drop_count < p_drops)
						why = WHY_BAD_EVENT;
					else begin
						more_drops = it.drop_count > p_drops;
						p_drops = it.drop_count;
						press = it.queue_depth >= p_press_lvl;
						recov = p_pressure && it.queue_depth <= p_recov_lvl;
						if (recov) p_pressure = 0;
						if (more_drops) begin
							p_pressure = p_pressure || press;
							why = WHY_DROP; key = 1;
							back_off(why, chg);
						end else if (press && !p_pressure) begin
							p_pressure = 1;
							why = WHY_PRESSURE;
							back_off(why, chg);
						end else
							why = recov ? WHY_RECOVERED : WHY_STABLE;
					end
				end
				EV_RENDERED: why = WHY_RENDERED;
				EV_AWAIT: begin why = WHY_AWAIT; key = 1; end
				default: begin why = WHY_REQUEST; key = 1; end
			endcase
		end
		r.why = why; r.rate_after = p_rate; r.rate_changed = chg; r.want_keyframe = key;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	task automatic idle_cycles(int unsigned n);
		repeat (n) @(posedge clk);
	endtask

	// write a register while the block is idle; the caller drops the enable
	task automatic write_reg(reg_idx_t idx, logic [31:0] v);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
		@(posedge clk);
		predict_config(idx, v);
	endtask

	// stop offering and wait until every result is back
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (decisions_due.size() != 0) @(posedge clk);
		idle_cycles(300);
	endtask

	task automatic load_plan(logic [31:0] mn, logic [31:0] st, logic [31:0] mx,
			logic [31:0] pl, logic [31:0] rl);
		write_reg(REG_MIN_RATE, mn);
		write_reg(REG_START_RATE, st);
		write_reg(REG_MAX_RATE, mx);
		write_reg(REG_PRESS_LVL, pl);
		write_reg(REG_RECOV_LVL, rl);
		cfg_we <= 1'b0;
	endtask

	// offer one item and hold it until taken; valid stays up for the next item
	task automatic send_item(fbb_in_t it);
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			idle_cycles($urandom_range(1, 19));
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		do @(posedge clk); while (!in_ch.ready);
		decisions_due.insert(decisions_due.size(), predict_decision(it));
	endtask

	function automatic fbb_in_t make_item(logic op, logic [3:0] kind, logic [63:0] tag,
			logic [63:0] frame, logic [31:0] drops, logic [31:0] depth, logic [31:0] misses);
		fbb_in_t it;
		it.op = op; it.session_tag = tag; it.event_kind = kind;
		it.event_seq = {$urandom} | 32'd1; it.frame_id = frame; it.drop_count = drops;
		it.queue_depth = depth; it.chunk_misses = misses;
		return it;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// random item, mostly well formed within the current session
	function automatic fbb_in_t random_item();
		fbb_in_t it;
		int unsigned pick;
		logic [63:0] f;
		pick = $urandom_range(0, 99);
		it = make_item(1'b1, EV_NONE, p_session, 0, p_drops, 0, {$urandom} | 1);
		it.event_kind = ev_kind_t'($urandom_range(1, 8));
		if (pick < 3) begin
			it.op = 1'b0;
			it.session_tag = ($urandom_range(0, 9) == 0) ? 64'd0 : rand64();
		end else if (pick < 8) begin
			it = make_item(1'b1, 4'($urandom), rand64(), rand64(), $urandom, $urandom, $urandom);
			if ($urandom_range(0, 1)) it.event_seq = 0;
		end else if (pick < 55) begin
			it.event_kind = ($urandom_range(0, 1)) ? EV_LOST : EV_CLOSS;
			if (recent_frames.size() != 0 && $urandom_range(0, 3) == 0)
				f = recent_frames[$urandom_range(0, recent_frames.size() - 1)];
			else begin
				f = ($urandom_range(0, 30) == 0) ? 64'd0 : rand64();
				recent_frames.insert(recent_frames.size(), f);
				if (recent_frames.size() > 400) recent_frames.delete(0);
			end
			it.frame_id = f;
			if ($urandom_range(0, 20) == 0) it.chunk_misses = 0;
		end else if (pick < 80) begin
			it.event_kind = EV_QUEUE;
			case ($urandom_range(0, 3))
				0: it.drop_count = p_drops + $urandom_range(1, 3);
				1: it.drop_count = p_drops - $urandom_range(0, 2);
				default: it.drop_count = p_drops;
			endcase
			it.queue_depth = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6);
		end
		return it;
	endfunction

	// check each result against the oldest expectation
	always @(posedge clk) begin
		fbb_out_t got, want;
		if (out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (decisions_due.size() == 0) begin
				report_mismatch("unexpected decision", 64'(got.decision_num), 64'd0);
			end else begin
				want = decisions_due[0];
				decisions_due.delete(0);
				if (got.accepted !== want.accepted)
					report_mismatch("accepted", 64'(got.accepted), 64'(want.accepted));
				if (got.decision_num !== want.decision_num)
					report_mismatch("decision_num", 64'(got.decision_num),
						64'(want.decision_num));
				if (got.why !== want.why)
					report_mismatch("why", 64'(got.why), 64'(want.why));
				if (got.rate_before !== want.rate_before)
					report_mismatch("rate_before", 64'(got.rate_before),
						64'(want.rate_before));
				if (got.rate_after !== want.rate_after)
					report_mismatch("rate_after", 64'(got.rate_after), 64'(want.rate_after));
				if (got.rate_changed !== want.rate_changed)
					report_mismatch("rate_changed", 64'(got.rate_changed),
						64'(want.rate_changed));
				if (got.want_keyframe !== want.want_keyframe)
					report_mismatch("want_keyframe", 64'(got.want_keyframe),
						64'(want.want_keyframe));
			end
		end
	end

	// receiver: random stall bursts, a forced long hold, none near the end
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (sink_hold)
				out_ch.ready <= 1'b0;
			else if (!no_idle && $urandom_range(0, 7) == 0) begin
				out_ch.ready <= 1'b0;
				idle_cycles($urandom_range(1, 19) - 1);
			end else
				out_ch.ready <= 1'b1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	typedef struct {
		fbb_in_t  item;
		bit       typed;
		fbb_out_t want;
	} directed_row_t;

	initial begin
		directed_row_t rows [$];
		directed_row_t row;
		fbb_out_t exp_r;
		logic [63:0] s1;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		predict_reset();
		idle_cycles(10);
		arst_n <= 1'b1;
		idle_cycles(2);

		// invalid plan after reset: refused start and bad-plan event
		s1 = 64'hFFFF_FFFF_FFFF_FFFF;
		exp_r = '0;
		rows.insert(rows.size(), '{make_item(0, EV_NONE, s1, 0, 0, 0, 0), 1'b1, exp_r});
		exp_r.accepted = 1;
		rows.insert(rows.size(), '{make_item(1, EV_ACK, s1, 0, 0, 0, 1), 1'b1, exp_r});
		foreach (rows[i]) begin
			row = rows[i];
			send_item(row.item);
			if (row.typed && decisions_due[$] != row.want)
				report_mismatch($sformatf("directed row %0d", i),
					64'(decisions_due[$].why), 64'(row.want.why));
		end
		drain();

		// directed part with a valid plan, extremes of the fields
		load_plan(32'd100, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd3, 32'd1);
		rows.delete();
		exp_r = '0;
		exp_r.rate_before = 32'hFFFF_FFFF; exp_r.rate_after = 32'hFFFF_FFFF;
		rows.insert(rows.size(), '{make_item(1'b0, EV_NONE, 64'd0, 0, 0, 0, 0), 1'b1, exp_r});
		exp_r.accepted = 1;
		rows.insert(rows.size(), '{make_item(1'b0, EV_NONE, s1, 0, 0, 0, 0), 1'b1, exp_r});
		rows.insert(rows.size(), '{make_item(1, EV_NONE, s1, 1, 0, 0, 1), 1'b0, exp_r});
		rows.insert(rows.size(), '{make_item(1, 4'hF, s1, 1, 0, 0, 1), 1'b0, exp_r});
		row = '{make_item(1, EV_ACK, s1, 1, 0, 0, 1), 1'b0, exp_r};
		row.item.event_seq = 0;
		rows.insert(rows.size(), row);
		rows.insert(rows.size(), '{make_item(1, EV_ACK, 64'd5, 1, 0, 0, 1), 1'b0, exp_r});
		for (int k = EV_ACK; k <= EV_KEYREQ; k++)
			rows.insert(rows.size(),
				'{make_item(1, 4'(k), s1, s1, 0, 0, 32'hFFFF_FFFF), 1'b0, exp_r});
		rows.insert(rows.size(), '{make_item(1, EV_LOST, s1, s1, 0, 0, 1), 1'b0, exp_r});
		rows.insert(rows.size(), '{make_item(1, EV_LOST, s1, 0, 0, 0, 1), 1'b0, exp_r});
		rows.insert(rows.size(), '{make_item(1, EV_CLOSS, s1, 7, 0, 0, 0), 1'b0, exp_r});
		rows.insert(rows.size(),
			'{make_item(1, EV_QUEUE, s1, 0, 32'hFFFF_FFFF, 5, 0), 1'b0, exp_r});
		rows.insert(rows.size(), '{make_item(1, EV_QUEUE, s1, 0, 3, 0, 0), 1'b0, exp_r});
		rows.insert(rows.size(),
			'{make_item(1, EV_QUEUE, s1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0), 1'b0, exp_r});
		rows.insert(rows.size(),
			'{make_item(1, EV_QUEUE, s1, 0, 32'hFFFF_FFFF, 0, 0), 1'b0, exp_r});
		// typed rows are the two starts at the head of this table
		foreach (rows[i]) begin
			row = rows[i];
			send_item(row.item);
			if (row.typed && decisions_due[$] != row.want)
				report_mismatch($sformatf("directed row %0d", i),
					64'(decisions_due[$].accepted), 64'(row.want.accepted));
		end
		drain();

		// rate at the floor: cuts hold at minimum
		load_plan(32'd1, 32'd1, 32'd1, 32'd0, 32'hFFFF_FFFF);
		send_item(make_item(0, EV_NONE, 64'd9, 0, 0, 0, 0));
		send_item(make_item(1, EV_LOST, 64'd9, 64'd3, 0, 0, 1));
		send_item(make_item(1, EV_QUEUE, 64'd9, 0, 0, 32'd0, 0));
		drain();

		// random phases over several plans
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: load_plan(32'd1000, 32'd8000000, 32'd10000000, 32'd3, 32'd1);
				1: load_plan(32'd1, 32'd9, 32'd9, 32'd2, 32'd0);
				2: load_plan(32'd50, 32'd40, 32'd60, 32'd3, 32'd1);
				3: load_plan($urandom_range(1, 1000), 32'hFFFF_FFF0, 32'hFFFF_FFFF,
					$urandom_range(0, 6), $urandom_range(0, 4));
				4: load_plan(32'd100000, 32'd5000000, 32'd5000000, 32'hFFFF_FFFF, 32'd0);
				default: load_plan(32'd7, 32'd3000, 32'd4000, 32'd4, 32'd2);
			endcase
			send_item(make_item(0, EV_NONE, rand64() | 64'd1, 0, 0, 0, 0));
			if (ph == 5) no_idle = 1'b1;
			for (int n = 0; n < 220; n++) begin
				send_item(random_item());
				// long receiver hold while the sender keeps offering
				if (ph == 1 && n == 50) begin
					fork
						begin
							sink_hold = 1'b1;
							idle_cycles(3000);
							sink_hold = 1'b0;
						end
					join_none
				end
				// sender pause until everything is back
				if (ph == 2 && n == 100) begin
					in_ch.valid <= 1'b0;
					while (decisions_due.size() != 0) @(posedge clk);
				end
			end
			drain();
		end

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
